>>> rtl/nsds_pkg.sv
// ----------------------------------------------------------------------------
// nsds_pkg: shared types and constants for the send-delay scheduler
// Widths, register map codes, reset values, sequencer states and the
// control/status structs between the top level and the divider.
// ----------------------------------------------------------------------------
package nsds_pkg;

    // time base and datapath widths
    localparam int TIME_BITS = 48;
    localparam int LEN_W     = 32;
    localparam int REG_W     = 32;
    localparam int PROD_W    = 2 * LEN_W;
    localparam int ADDR_W    = 5;
    localparam int BASE_W    = REG_W - 1;
    localparam int SUM_W     = TIME_BITS + 1;
    localparam int EXT_W     = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;

    localparam logic [TIME_BITS-1:0] TIME_MASK = '1;

    // divider: quotient bits retired per cycle
    localparam int DIV_STEPS = 2;
    localparam int DIV_CNT   = PROD_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_CNT);

    // register reset values
    localparam logic [REG_W-1:0] RST_P0_LEN = 32'd0;
    localparam logic [REG_W-1:0] RST_P1_LEN = 32'd1024;
    localparam logic [REG_W-1:0] RST_P2_LEN = 32'd65536;
    localparam logic [REG_W-1:0] RST_LAT    = 32'd0;
    localparam logic [REG_W-1:0] RST_GAP    = 32'd0;

    // register map, word index
    typedef enum logic [2:0] {
        REG_P0_LEN = 3'd0,
        REG_P0_LAT = 3'd1,
        REG_P1_LEN = 3'd2,
        REG_P1_LAT = 3'd3,
        REG_P2_LEN = 3'd4,
        REG_P2_LAT = 3'd5,
        REG_GAP    = 3'd6
    } reg_idx_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG,
        ST_MULT,
        ST_LOAD,
        ST_DIV,
        ST_COST,
        ST_SUM,
        ST_DELAY,
        ST_SLOT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [LEN_W-1:0]  divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
    } div_stat_t;

endpackage

>>> rtl/nsds_div.sv
// ----------------------------------------------------------------------------
// nsds_div: iterative unsigned divider
// Restoring division of a PROD_W-bit dividend by a LEN_W-bit divisor,
// DIV_STEPS quotient bits per cycle. Quotient holds after done pulses.
// ----------------------------------------------------------------------------
module nsds_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  nsds_pkg::div_ctrl_t ctrl_i,
    output nsds_pkg::div_stat_t stat_o
);

    logic [nsds_pkg::PROD_W-1:0]    quot_reg, quot_next;
    logic [nsds_pkg::LEN_W-1:0]     rem_reg, rem_next;
    logic [nsds_pkg::LEN_W-1:0]     dvs_reg, dvs_next;
    logic [nsds_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           run_reg, run_next;
    logic                           done_reg, done_next;

    logic [nsds_pkg::PROD_W-1:0]    quo_v;
    logic [nsds_pkg::LEN_W-1:0]     rem_v;
    logic [nsds_pkg::LEN_W:0]       trial;

    // DIV_STEPS restoring steps per cycle
    always_comb begin
        rem_v = rem_reg;
        quo_v = quot_reg;
        trial = '0;
        for (int i = 0; i < nsds_pkg::DIV_STEPS; i++) begin
            trial = {rem_v, quo_v[nsds_pkg::PROD_W-1]};
            quo_v = {quo_v[nsds_pkg::PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                trial    = trial - {1'b0, dvs_reg};
                quo_v[0] = 1'b1;
            end
            rem_v = trial[nsds_pkg::LEN_W-1:0];
        end
    end

    // iteration control
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctrl_i.start) begin
            quot_next = ctrl_i.dividend;
            rem_next  = '0;
            dvs_next  = ctrl_i.divisor;
            cnt_next  = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            quot_next = quo_v;
            rem_next  = rem_v;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == nsds_pkg::DIV_CNT_W'(nsds_pkg::DIV_CNT - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
    end

    assign stat_o.done = done_reg;
    assign stat_o.quot = quot_reg;

endmodule

>>> rtl/nic_send_delay_scheduler_top.sv
// ----------------------------------------------------------------------------
// nic_send_delay_scheduler_top: per-message send delay from a cost table
// Piecewise-linear message cost over three breakpoints plus tracking of
// the next free send slot.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per outgoing message (length, current time).
//   m_* channel: one transaction per message (send delay, busy wait, busy flag).
//   APB port: seven 32-bit registers at 4*i (three length/latency breakpoints,
//   then send_gap); write them only while no message is in flight.
// Timing:
//   A message runs through segment select, one 32x32 multiply, divider load,
//   the divider (two quotient bits per cycle on a 64-bit dividend, then done),
//   then cost, sum, delay and slot arithmetic. s_ready returns high the cycle
//   after the result is registered, so a new message is taken only once the
//   last one is through.
// Reset:
//   aresetn (sync, active low) restores register defaults, clears the next
//   free slot to zero and empties the output register.
// Stall:
//   The result sits in an output register; while it is not taken the next
//   message still runs, and finishes only once the register is free.
// ----------------------------------------------------------------------------
module nic_send_delay_scheduler_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [nsds_pkg::LEN_W-1:0]     s_message_length,
    input  logic [nsds_pkg::TIME_BITS-1:0] s_current_time,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nsds_pkg::TIME_BITS-1:0] m_send_delay,
    output logic [nsds_pkg::TIME_BITS-1:0] m_busy_wait,
    output logic                           m_was_busy,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nsds_pkg::ADDR_W-1:0]    paddr,
    input  logic [nsds_pkg::REG_W-1:0]     pwdata,
    output logic [nsds_pkg::REG_W-1:0]     prdata,
    output logic                           pready
);

    localparam int TB = nsds_pkg::TIME_BITS;
    localparam int LW = nsds_pkg::LEN_W;
    localparam int PW = nsds_pkg::PROD_W;
    localparam int EW = nsds_pkg::EXT_W;

    // configuration registers
    logic [nsds_pkg::REG_W-1:0] p0_len_reg, p0_lat_reg, p1_len_reg, p1_lat_reg;
    logic [nsds_pkg::REG_W-1:0] p2_len_reg, p2_lat_reg, gap_reg;
    nsds_pkg::reg_idx_t         cfg_idx;
    logic                       cfg_wr;

    // sequencer and datapath registers
    nsds_pkg::state_t             state_reg, state_next;
    logic [LW-1:0]                len_reg, len_next;
    logic [TB-1:0]                now_reg, now_next;
    logic [TB-1:0]                nfs_reg, nfs_next;
    logic [LW-1:0]                dmag_reg, dmag_next;
    logic [LW-1:0]                rmag_reg, rmag_next;
    logic [LW-1:0]                runmag_reg, runmag_next;
    logic                         slope_ok_reg, slope_ok_next;
    logic                         qneg_reg, qneg_next;
    logic [nsds_pkg::BASE_W-1:0]  base_reg, base_next;
    logic                         busy_reg, busy_next;
    logic [TB-1:0]                wait_reg, wait_next;
    logic [PW-1:0]                prod_reg, prod_next;
    logic                         cneg_reg, cneg_next;
    logic [PW-1:0]                cmag_reg, cmag_next;
    logic [nsds_pkg::SUM_W-1:0]   s_reg, s_next;
    logic [TB-1:0]                delay_reg, delay_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [TB-1:0]                m_delay_reg, m_delay_next;
    logic [TB-1:0]                m_wait_reg, m_wait_next;
    logic                         m_busy_reg, m_busy_next;

    nsds_pkg::div_ctrl_t          div_ctrl;
    nsds_pkg::div_stat_t          div_stat;

    // segment select scratch
    logic                         lo_sel;
    logic [LW-1:0]                xs_lo, xs_hi, ys_lo, ys_hi;
    logic [LW:0]                  rise, run, len_off;
    logic [LW:0]                  rise_abs, run_abs, dist_abs;
    // cost / delay / slot scratch
    logic [PW:0]                  csum;
    logic [EW-1:0]                s_ext, m_ext, add_ext, dif_ext, now_ext, mask_ext;
    logic [TB:0]                  slot_sum;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = nsds_pkg::reg_idx_t'(paddr[nsds_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_len_reg <= nsds_pkg::RST_P0_LEN;
            p0_lat_reg <= nsds_pkg::RST_LAT;
            p1_len_reg <= nsds_pkg::RST_P1_LEN;
            p1_lat_reg <= nsds_pkg::RST_LAT;
            p2_len_reg <= nsds_pkg::RST_P2_LEN;
            p2_lat_reg <= nsds_pkg::RST_LAT;
            gap_reg    <= nsds_pkg::RST_GAP;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                nsds_pkg::REG_P0_LEN: p0_len_reg <= pwdata;
                nsds_pkg::REG_P0_LAT: p0_lat_reg <= pwdata;
                nsds_pkg::REG_P1_LEN: p1_len_reg <= pwdata;
                nsds_pkg::REG_P1_LAT: p1_lat_reg <= pwdata;
                nsds_pkg::REG_P2_LEN: p2_len_reg <= pwdata;
                nsds_pkg::REG_P2_LAT: p2_lat_reg <= pwdata;
                nsds_pkg::REG_GAP:    gap_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            nsds_pkg::REG_P0_LEN: prdata = p0_len_reg;
            nsds_pkg::REG_P0_LAT: prdata = p0_lat_reg;
            nsds_pkg::REG_P1_LEN: prdata = p1_len_reg;
            nsds_pkg::REG_P1_LAT: prdata = p1_lat_reg;
            nsds_pkg::REG_P2_LEN: prdata = p2_len_reg;
            nsds_pkg::REG_P2_LAT: prdata = p2_lat_reg;
            nsds_pkg::REG_GAP:    prdata = gap_reg;
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // segment select: first breakpoint above the length, else last pair
    // ------------------------------------------------------------------
    always_comb begin
        lo_sel   = p1_len_reg > len_reg;
        xs_lo    = lo_sel ? p0_len_reg : p1_len_reg;
        xs_hi    = lo_sel ? p1_len_reg : p2_len_reg;
        ys_lo    = lo_sel ? p0_lat_reg : p1_lat_reg;
        ys_hi    = lo_sel ? p1_lat_reg : p2_lat_reg;
        rise     = {ys_hi[LW-1], ys_hi} - {ys_lo[LW-1], ys_lo};
        run      = {1'b0, xs_hi} - {1'b0, xs_lo};
        len_off  = {1'b0, len_reg} - {1'b0, xs_lo};
        rise_abs = rise[LW] ? -rise : rise;
        run_abs  = run[LW]  ? -run  : run;
        dist_abs = len_off[LW] ? -len_off : len_off;
    end

    // ------------------------------------------------------------------
    // cost, delay and slot arithmetic
    // ------------------------------------------------------------------
    always_comb begin
        csum     = {1'b0, div_stat.quot} + (PW + 1)'(base_reg);
        s_ext    = EW'(s_reg);
        m_ext    = EW'(cmag_reg);
        now_ext  = EW'(now_reg);
        mask_ext = EW'(nsds_pkg::TIME_MASK);
        add_ext  = s_ext + m_ext;
        dif_ext  = s_ext - m_ext;
        slot_sum = {1'b0, now_reg} + {1'b0, delay_reg};
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        now_next      = now_reg;
        nfs_next      = nfs_reg;
        dmag_next     = dmag_reg;
        rmag_next     = rmag_reg;
        runmag_next   = runmag_reg;
        slope_ok_next = slope_ok_reg;
        qneg_next     = qneg_reg;
        base_next     = base_reg;
        busy_next     = busy_reg;
        wait_next     = wait_reg;
        prod_next     = prod_reg;
        cneg_next     = cneg_reg;
        cmag_next     = cmag_reg;
        s_next        = s_reg;
        delay_next    = delay_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        m_delay_next  = m_delay_reg;
        m_wait_next   = m_wait_reg;
        m_busy_next   = m_busy_reg;
        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = prod_reg;
        div_ctrl.divisor  = runmag_reg;

        unique case (state_reg)
            nsds_pkg::ST_IDLE: begin
                if (s_valid) begin
                    len_next   = s_message_length;
                    now_next   = s_current_time;
                    state_next = nsds_pkg::ST_SEG;
                end
            end
            // segment values and slot compare
            nsds_pkg::ST_SEG: begin
                dmag_next     = dist_abs[LW-1:0];
                rmag_next     = rise_abs[LW-1:0];
                runmag_next   = run_abs[LW-1:0];
                slope_ok_next = (|rise) && (|run) && (rise[LW] == run[LW]);
                qneg_next     = (|rise) && (|run) && (rise[LW] == run[LW]) && len_off[LW];
                base_next     = ys_lo[LW-1] ? '0 : ys_lo[nsds_pkg::BASE_W-1:0];
                busy_next     = now_reg <= nfs_reg;
                wait_next     = (now_reg <= nfs_reg) ? nfs_reg - now_reg : '0;
                state_next    = nsds_pkg::ST_MULT;
            end
            // |d| * |rise|; a flat segment divides zero by one
            nsds_pkg::ST_MULT: begin
                prod_next   = slope_ok_reg ? dmag_reg * rmag_reg : '0;
                runmag_next = slope_ok_reg ? runmag_reg : LW'(1);
                state_next  = nsds_pkg::ST_LOAD;
            end
            nsds_pkg::ST_LOAD: begin
                div_ctrl.start = 1'b1;
                state_next     = nsds_pkg::ST_DIV;
            end
            nsds_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = nsds_pkg::ST_COST;
                end
            end
            // signed cost = base +/- quotient, positive side clamped
            nsds_pkg::ST_COST: begin
                if (!qneg_reg) begin
                    cneg_next = 1'b0;
                    cmag_next = (csum > (PW + 1)'(nsds_pkg::TIME_MASK)) ?
                                PW'(nsds_pkg::TIME_MASK) : csum[PW-1:0];
                end else if (div_stat.quot > PW'(base_reg)) begin
                    cneg_next = 1'b1;
                    cmag_next = div_stat.quot - PW'(base_reg);
                end else begin
                    cneg_next = 1'b0;
                    cmag_next = PW'(base_reg) - div_stat.quot;
                end
                state_next = nsds_pkg::ST_SUM;
            end
            nsds_pkg::ST_SUM: begin
                s_next     = {1'b0, wait_reg} + nsds_pkg::SUM_W'(gap_reg);
                state_next = nsds_pkg::ST_DELAY;
            end
            // delay, floored at zero and saturated
            nsds_pkg::ST_DELAY: begin
                if (!busy_reg) begin
                    delay_next = cneg_reg ? '0 : cmag_reg[TB-1:0];
                end else if (!cneg_reg) begin
                    delay_next = (add_ext > mask_ext) ? nsds_pkg::TIME_MASK : add_ext[TB-1:0];
                end else if (s_ext >= m_ext) begin
                    delay_next = (dif_ext > mask_ext) ? nsds_pkg::TIME_MASK : dif_ext[TB-1:0];
                end else begin
                    delay_next = '0;
                end
                state_next = nsds_pkg::ST_SLOT;
            end
            // next free slot and result, once the output register is free
            nsds_pkg::ST_SLOT: begin
                if (!m_valid_reg || m_ready) begin
                    if (!busy_reg && cneg_reg) begin
                        nfs_next = (m_ext >= now_ext) ? '0 : now_reg - cmag_reg[TB-1:0];
                    end else begin
                        nfs_next = slot_sum[TB] ? nsds_pkg::TIME_MASK : slot_sum[TB-1:0];
                    end
                    m_valid_next = 1'b1;
                    m_delay_next = delay_reg;
                    m_wait_next  = wait_reg;
                    m_busy_next  = busy_reg;
                    state_next   = nsds_pkg::ST_IDLE;
                end
            end
            default: state_next = nsds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nsds_pkg::ST_IDLE;
            nfs_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            nfs_reg     <= nfs_next;
            m_valid_reg <= m_valid_next;
        end
        len_reg      <= len_next;
        now_reg      <= now_next;
        dmag_reg     <= dmag_next;
        rmag_reg     <= rmag_next;
        runmag_reg   <= runmag_next;
        slope_ok_reg <= slope_ok_next;
        qneg_reg     <= qneg_next;
        base_reg     <= base_next;
        busy_reg     <= busy_next;
        wait_reg     <= wait_next;
        prod_reg     <= prod_next;
        cneg_reg     <= cneg_next;
        cmag_reg     <= cmag_next;
        s_reg        <= s_next;
        delay_reg    <= delay_next;
        m_delay_reg  <= m_delay_next;
        m_wait_reg   <= m_wait_next;
        m_busy_reg   <= m_busy_next;
    end

    // divider
    nsds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_i  (div_ctrl),
        .stat_o  (div_stat)
    );

    assign s_ready      = (state_reg == nsds_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_send_delay = m_delay_reg;
    assign m_busy_wait  = m_wait_reg;
    assign m_was_busy   = m_busy_reg;

endmodule

>>> tb/sv/nic_send_delay_scheduler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nic_send_delay_scheduler_top_test: self-checking bench for the send-delay scheduler
// Feeds messages (length, time) through the s_ channel under random idling,
// predicts delay, busy wait and busy flag from a local copy of the cost table
// and next free slot, and checks every m_ transaction in order. The table is
// reprogrammed over APB between phases, only while nothing is in flight.
// ----------------------------------------------------------------------------
module nic_send_delay_scheduler_top_test;

    localparam int NUM_CFG_REGS   = 7;
    localparam int REG_UNMAPPED   = 7;
    localparam int IDLE_PCT       = 19;
    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 78;

    typedef struct {
        logic [nsds_pkg::LEN_W-1:0]     len;
        logic [nsds_pkg::TIME_BITS-1:0] now;
    } msg_item_t;

    typedef struct {
        logic [nsds_pkg::TIME_BITS-1:0] send_delay;
        logic [nsds_pkg::TIME_BITS-1:0] busy_wait;
        logic                           was_busy;
    } send_result_t;

    // DUT ports, all driven from time zero
    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [nsds_pkg::LEN_W-1:0]     s_message_length = '0;
    logic [nsds_pkg::TIME_BITS-1:0] s_current_time = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [nsds_pkg::TIME_BITS-1:0] m_send_delay;
    logic [nsds_pkg::TIME_BITS-1:0] m_busy_wait;
    logic                           m_was_busy;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [nsds_pkg::ADDR_W-1:0]    paddr = '0;
    logic [nsds_pkg::REG_W-1:0]     pwdata = '0;
    logic [nsds_pkg::REG_W-1:0]     prdata;
    logic                           pready;

    // predictor state: shadow of the register file and the next free slot
    logic [nsds_pkg::REG_W-1:0]     cfg_regs [NUM_CFG_REGS];
    logic [nsds_pkg::TIME_BITS-1:0] slot_next;

    msg_item_t    msg_pending [$];
    send_result_t send_expected [$];
    int           error_count = 0;
    int           stall_cycles = 0;
    bit           steady_flow = 1'b0;
    logic [nsds_pkg::TIME_BITS-1:0] time_base = '0;

    nic_send_delay_scheduler_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_message_length (s_message_length),
        .s_current_time   (s_current_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_send_delay     (m_send_delay),
        .m_busy_wait      (m_busy_wait),
        .m_was_busy       (m_was_busy),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 aclk = ~aclk;

    function automatic bit take_gap();
        return !steady_flow && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic logic [nsds_pkg::TIME_BITS-1:0] sat_time(input logic [64:0] v);
        return (v > {17'd0, nsds_pkg::TIME_MASK}) ? nsds_pkg::TIME_MASK
                                                  : v[nsds_pkg::TIME_BITS-1:0];
    endfunction

    // Piecewise-linear cost, returned as sign and magnitude
    function automatic void message_cost(input logic [nsds_pkg::LEN_W-1:0] len,
                                         output bit neg, output logic [64:0] mag);
        longint      xs [3];
        longint      ys [3];
        int          lo, hi;
        longint      rise, run, d;
        logic [63:0] base, q, a_d, a_rise, a_run;
        logic [64:0] sum;
        bit          qneg;
        xs[0] = cfg_regs[nsds_pkg::REG_P0_LEN];
        xs[1] = cfg_regs[nsds_pkg::REG_P1_LEN];
        xs[2] = cfg_regs[nsds_pkg::REG_P2_LEN];
        ys[0] = longint'(signed'(cfg_regs[nsds_pkg::REG_P0_LAT]));
        ys[1] = longint'(signed'(cfg_regs[nsds_pkg::REG_P1_LAT]));
        ys[2] = longint'(signed'(cfg_regs[nsds_pkg::REG_P2_LAT]));
        // first segment whose end lies beyond the length, else extrapolate
        lo = 1;
        hi = 2;
        if (xs[1] > longint'(len)) begin
            lo = 0;
            hi = 1;
        end
        rise = ys[hi] - ys[lo];
        run  = xs[hi] - xs[lo];
        base = (ys[lo] < 0) ? 64'd0 : 64'(ys[lo]);
        q    = '0;
        qneg = 1'b0;
        // zero run or falling slope both give a flat segment
        if (rise != 0 && run != 0 && ((rise > 0) == (run > 0))) begin
            d      = longint'(len) - xs[lo];
            a_d    = (d < 0) ? 64'(-d) : 64'(d);
            a_rise = (rise < 0) ? 64'(-rise) : 64'(rise);
            a_run  = (run < 0) ? 64'(-run) : 64'(run);
            q      = (a_d * a_rise) / a_run;
            qneg   = (d < 0);
        end
        if (!qneg) begin
            neg = 1'b0;
            sum = {1'b0, q} + {1'b0, base};
            mag = {17'd0, sat_time(sum)};
        end else if (q > base) begin
            neg = 1'b1;
            mag = {1'b0, q - base};
        end else begin
            neg = 1'b0;
            mag = {1'b0, base - q};
        end
    endfunction

    // Expected result of one message; advances the next free slot
    function automatic send_result_t schedule_message(
            input logic [nsds_pkg::LEN_W-1:0] len,
            input logic [nsds_pkg::TIME_BITS-1:0] now);
        send_result_t r;
        bit           neg;
        logic [64:0]  mag, wait_plus_gap, total;
        message_cost(len, neg, mag);
        r.was_busy  = (now <= slot_next);
        r.busy_wait = '0;
        if (!r.was_busy) begin
            r.send_delay = neg ? '0 : mag[nsds_pkg::TIME_BITS-1:0];
            if (neg)
                slot_next = (mag >= {17'd0, now}) ? '0 : now - mag[nsds_pkg::TIME_BITS-1:0];
            else
                slot_next = sat_time({17'd0, now} + mag);
        end else begin
            r.busy_wait   = slot_next - now;
            wait_plus_gap = {17'd0, r.busy_wait} + {33'd0, cfg_regs[nsds_pkg::REG_GAP]};
            if (!neg)
                total = wait_plus_gap + mag;
            else
                total = (wait_plus_gap >= mag) ? wait_plus_gap - mag : '0;
            r.send_delay = sat_time(total);
            slot_next    = sat_time({17'd0, now} + {17'd0, r.send_delay});
        end
        return r;
    endfunction

    // Input driver: predict on acceptance, then present the next message
    always @(posedge aclk) begin : msg_driver
        msg_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                send_expected.push_back(schedule_message(s_message_length, s_current_time));
            if (!s_valid || s_ready) begin
                if (msg_pending.size() > 0 && !take_gap()) begin
                    item = msg_pending.pop_front();
                    s_valid          <= 1'b1;
                    s_message_length <= item.len;
                    s_current_time   <= item.now;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: in-order compare against the oldest expectation
    always @(posedge aclk) begin : result_monitor
        send_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (send_expected.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result delay=%h wait=%h busy=%b",
                                 $realtime, m_send_delay, m_busy_wait, m_was_busy);
                end else begin
                    want = send_expected.pop_front();
                    if (m_send_delay !== want.send_delay || m_busy_wait !== want.busy_wait
                            || m_was_busy !== want.was_busy) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: mismatch exp delay=%h wait=%h busy=%b, got %h %h %b",
                                     $realtime, want.send_delay, want.busy_wait,
                                     want.was_busy, m_send_delay, m_busy_wait, m_was_busy);
                    end
                end
            end
            m_ready <= !take_gap();
        end
    end

    // Cycles since the last transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("nic_send_delay_scheduler_top_test NOT OK");
        $finish;
    end

    // APB write: setup then access; shadow copy ignores unmapped indexes
    task automatic apb_write(input int idx, input logic [nsds_pkg::REG_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= nsds_pkg::ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_CFG_REGS)
            cfg_regs[idx] = value;
    endtask

    task automatic set_table(input logic [31:0] x0, y0, x1, y1, x2, y2, gap);
        apb_write(nsds_pkg::REG_P0_LEN, x0);
        apb_write(nsds_pkg::REG_P0_LAT, y0);
        apb_write(nsds_pkg::REG_P1_LEN, x1);
        apb_write(nsds_pkg::REG_P1_LAT, y1);
        apb_write(nsds_pkg::REG_P2_LEN, x2);
        apb_write(nsds_pkg::REG_P2_LAT, y2);
        apb_write(nsds_pkg::REG_GAP, gap);
    endtask

    task automatic push_msg(input logic [nsds_pkg::LEN_W-1:0] len,
                            input logic [nsds_pkg::TIME_BITS-1:0] now);
        msg_item_t item;
        item.len = len;
        item.now = now;
        msg_pending.push_back(item);
    endtask

    // Block until every queued message has produced its result
    task automatic wait_drained();
        do @(negedge aclk);
        while (msg_pending.size() > 0 || s_valid || send_expected.size() > 0);
    endtask

    function automatic logic [nsds_pkg::TIME_BITS-1:0] rand_time();
        return nsds_pkg::TIME_BITS'({$urandom(), $urandom()});
    endfunction

    // A huge negative cost pulls the next free slot back to (or below) now
    task automatic rewind_send_slot(input logic [nsds_pkg::TIME_BITS-1:0] now);
        set_table(32'hFFFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
        push_msg(32'd0, now);
        wait_drained();
    endtask

    task automatic set_random_table(input bit wild);
        logic [31:0] x0, x1, x2;
        if (wild) begin
            set_table($urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom());
        end else begin
            x0 = $urandom_range(0, 300);
            x1 = x0 + (($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 3000)));
            x2 = x1 + 32'($urandom_range(0, 60000));
            set_table(x0, 32'($urandom_range(0, 40000)) - 32'd10000,
                      x1, 32'($urandom_range(0, 40000)) - 32'd10000,
                      x2, 32'($urandom_range(0, 40000)) - 32'd10000,
                      $urandom_range(0, 500));
        end
    endtask

    task automatic queue_random_messages(input int count, input bit wild);
        logic [nsds_pkg::LEN_W-1:0]     len, bp;
        logic [nsds_pkg::TIME_BITS-1:0] now;
        int                             pick;
        for (int i = 0; i < count; i++) begin
            // lengths: around breakpoints, anywhere, or within the table span
            pick = $urandom_range(0, 7);
            if (pick < 2) begin
                case ($urandom_range(0, 2))
                    0: bp = cfg_regs[nsds_pkg::REG_P0_LEN];
                    1: bp = cfg_regs[nsds_pkg::REG_P1_LEN];
                    default: bp = cfg_regs[nsds_pkg::REG_P2_LEN];
                endcase
                len = bp + 32'($urandom_range(0, 4)) - 32'd2;
            end else if (pick == 2 || wild) begin
                len = $urandom();
            end else begin
                len = $urandom_range(0, cfg_regs[nsds_pkg::REG_P2_LEN]
                                        + cfg_regs[nsds_pkg::REG_P2_LEN] / 2 + 16);
            end
            // times: mostly a running clock, sometimes jumps or near the top
            pick = $urandom_range(0, 19);
            if (wild && pick < 6) begin
                now = rand_time();
            end else if (wild && pick < 9) begin
                now = nsds_pkg::TIME_MASK - nsds_pkg::TIME_BITS'($urandom_range(0, 1000));
            end else if (pick == 0) begin
                now = rand_time();
            end else begin
                time_base = time_base + nsds_pkg::TIME_BITS'($urandom_range(0, 30000));
                now = time_base;
            end
            push_msg(len, now);
        end
    endtask

    initial begin : stimulus
        bit wild;
        cfg_regs[nsds_pkg::REG_P0_LEN] = nsds_pkg::RST_P0_LEN;
        cfg_regs[nsds_pkg::REG_P0_LAT] = nsds_pkg::RST_LAT;
        cfg_regs[nsds_pkg::REG_P1_LEN] = nsds_pkg::RST_P1_LEN;
        cfg_regs[nsds_pkg::REG_P1_LAT] = nsds_pkg::RST_LAT;
        cfg_regs[nsds_pkg::REG_P2_LEN] = nsds_pkg::RST_P2_LEN;
        cfg_regs[nsds_pkg::REG_P2_LAT] = nsds_pkg::RST_LAT;
        cfg_regs[nsds_pkg::REG_GAP]    = nsds_pkg::RST_GAP;
        slot_next = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset table: flat zero cost, busy at time zero, extreme fields
        push_msg(32'd0, '0);
        push_msg(32'hFFFF_FFFF, 48'd1);
        wait_drained();

        // negative base, rising first segment, falling second, small gap
        set_table(32'd100, -32'd50, 32'd1000, 32'd500, 32'd4000, 32'd200, 32'd7);
        push_msg(32'd0, 48'd1000);
        push_msg(32'd50, 48'd2000);
        push_msg(32'd100, 48'd1900);
        push_msg(32'd0, 48'd1950);
        push_msg(32'd999, 48'd3000);
        push_msg(32'd1000, 48'd3500);
        push_msg(32'd4000, 48'd10000);
        push_msg(32'hFFFF_FFFF, 48'd10001);
        push_msg(32'd3000, 48'd20000);
        wait_drained();

        // flat first segment, zero-length last segment, unmapped write ignored
        set_table(32'd0, 32'd1000, 32'd2000, 32'd1000, 32'd2000, 32'd5000, 32'd0);
        apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        push_msg(32'd0, 48'd30000);
        push_msg(32'd2000, 48'd30500);
        push_msg(32'hFFFF_FFFF, 48'd40000);
        wait_drained();

        // extremes: saturating cost, full gap, time at the top of range
        set_table(32'd0, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 32'd2, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF);
        push_msg(32'hFFFF_FFFF, 48'd50000);
        push_msg(32'd0, 48'd60000);
        push_msg(32'd0, nsds_pkg::TIME_MASK);
        push_msg(32'd5, nsds_pkg::TIME_MASK - 48'd1);
        wait_drained();

        // huge negative cost when busy, when idle, then busy at time zero
        rewind_send_slot(48'd100);
        push_msg(32'd0, 48'd200);
        push_msg(32'd1, 48'd0);
        wait_drained();

        // random phases, two with a fully random table
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wild = (ph == 3 || ph == 6);
            steady_flow = (ph == 2);
            time_base = (ph == 5) ? rand_time() : time_base;
            rewind_send_slot(time_base);
            set_random_table(wild);
            queue_random_messages(PHASE_ITEMS, wild);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (error_count == 0 && send_expected.size() == 0)
            $display("nic_send_delay_scheduler_top_test OK");
        else
            $display("nic_send_delay_scheduler_top_test NOT OK");
        $finish;
    end

endmodule
